// ===== rtl/core/meter_average_hysteresis_display_macros.svh =====
// ----------------------------------------------------------------------------
// Meter display assertion macros
// Shared concurrent assertion forms for the meter channel checkers.
// ----------------------------------------------------------------------------
`ifndef METER_AVERAGE_HYSTERESIS_DISPLAY_MACROS_SVH
`define METER_AVERAGE_HYSTERESIS_DISPLAY_MACROS_SVH

// base form: clocked on clk, quiet while arst_n is low
`define MAHD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define MAHD_ASSERT_IMPL(label, ante, cons, msg) \
	`MAHD_ASSERT(label, (ante) |-> (cons), msg)

// next-cycle implication
`define MAHD_ASSERT_NEXT(label, ante, cons, msg) \
	`MAHD_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/mahd_pkg.sv =====
// ----------------------------------------------------------------------------
// mahd_pkg
// Types, constants and helpers shared by the meter average / display block.
// ----------------------------------------------------------------------------
package mahd_pkg;

	// window geometry
	localparam int WINDOW_DEPTH = 32;
	localparam int SAMPLE_W     = 10;
	localparam int SUM_W        = SAMPLE_W + $clog2(WINDOW_DEPTH);
	localparam int AVG_W        = 10;

	// register widths
	localparam int LIMIT_W = 11;
	localparam int STEP_W  = 10;
	localparam int THR_W   = STEP_W + 4;
	localparam int SHOWN_W = 16;

	// result widths
	localparam int DIGIT_W = 4;
	localparam int DOT_W   = 2;

	// bus widths
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 16;
	localparam int OUT_USER_W = 2;

	// reset values
	localparam logic [LIMIT_W-1:0] LIMIT_RST = LIMIT_W'(1000);
	localparam logic [STEP_W-1:0]  STEP_RST  = STEP_W'(6);
	localparam logic [SHOWN_W-1:0] SHOWN_RST = SHOWN_W'(32767);

	// averages at or above this are shown scaled down by ten
	localparam logic [AVG_W-1:0] BIG_LIMIT = AVG_W'(1000);

	// register map, index = paddr[3:2]
	typedef enum logic [1:0] {
		REG_LIMIT = 2'd0,
		REG_STEP  = 2'd1,
		REG_MODE  = 2'd2
	} reg_idx_t;

	// input word kinds
	typedef enum logic {
		KIND_SAMPLE  = 1'b0,
		KIND_DISPLAY = 1'b1
	} kind_t;

	// display formats
	typedef enum logic {
		MODE_VOLTS = 1'b0,
		MODE_MILLI = 1'b1
	} mode_t;

	// dot positions
	typedef enum logic [DOT_W-1:0] {
		DOT_NONE       = 2'd0,
		DOT_AFTER_HIGH = 2'd1,
		DOT_AFTER_MID  = 2'd2
	} dot_t;

	// window status handed to the display path
	typedef struct packed {
		logic             over_flag;
		logic [SUM_W-1:0] sum;
	} win_status_t;

	// x / 100 for x below 1000
	function automatic logic [DIGIT_W-1:0] div100(input logic [AVG_W-1:0] x);
		logic [AVG_W+5:0] p;
		p = {6'd0, x} * (AVG_W+6)'(41);
		return DIGIT_W'(p >> 12);
	endfunction

	// x / 10 for x below 1024
	function automatic logic [6:0] div10(input logic [AVG_W-1:0] x);
		logic [AVG_W+7:0] p;
		p = {8'd0, x} * (AVG_W+8)'(205);
		return 7'(p >> 11);
	endfunction

endpackage

// ===== rtl/core/mahd_cell.sv =====
// ----------------------------------------------------------------------------
// mahd_cell
// One window slot: holds a reading and passes it on when a new one arrives.
// ----------------------------------------------------------------------------
module mahd_cell
	import mahd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                shift,
	input  logic [SAMPLE_W-1:0] din,
	output logic [SAMPLE_W-1:0] dout
);

	logic [SAMPLE_W-1:0] slot_q;

	// slot register, window starts all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (shift) begin
			slot_q <= din;
		end
	end

	assign dout = slot_q;

endmodule

// ===== rtl/core/mahd_window.sv =====
// ----------------------------------------------------------------------------
// mahd_window
// Chain of window cells with a running sum and the overflow flag.
// ----------------------------------------------------------------------------
module mahd_window
	import mahd_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                sample_take,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [LIMIT_W-1:0]  overflow_limit,
	output win_status_t         status
);

	logic [SAMPLE_W-1:0] tap [WINDOW_DEPTH+1];
	logic                over;
	logic                push;
	logic [SUM_W-1:0]    sum_q;
	logic                over_flag_q;

	// range check against the limit
	assign over = {1'b0, sample} >= overflow_limit;
	assign push = sample_take && !over;

	// cell chain: newest enters at tap 0, oldest leaves at the far end
	assign tap[0] = sample;
	for (genvar i = 0; i < WINDOW_DEPTH; i++) begin : g_cell
		mahd_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (push),
			.din    (tap[i]),
			.dout   (tap[i+1])
		);
	end

	// running sum and flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q       <= '0;
			over_flag_q <= 1'b0;
		end else if (sample_take) begin
			over_flag_q <= over;
			if (!over) begin
				sum_q <= sum_q - SUM_W'(tap[WINDOW_DEPTH]) + SUM_W'(sample);
			end
		end
	end

	assign status.over_flag = over_flag_q;
	assign status.sum       = sum_q;

endmodule

// ===== rtl/core/mahd_display.sv =====
// ----------------------------------------------------------------------------
// mahd_display
// Hysteresis decision, digit split and the result output register.
// ----------------------------------------------------------------------------
module mahd_display
	import mahd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  disp_take,
	output logic                  take_ready,
	input  win_status_t           status,
	input  logic [STEP_W-1:0]     hysteresis_step,
	input  logic                  format_mode,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [OUT_DATA_W-1:0] out_data,
	output logic [OUT_USER_W-1:0] out_user
);

	logic [AVG_W-1:0]   avg;
	logic               big;
	logic [SHOWN_W-1:0] diff;
	logic [SHOWN_W-1:0] mag;
	logic [THR_W-1:0]   thr;
	logic               draw;
	logic [AVG_W-1:0]   x_show;
	dot_t               dot;
	logic [SHOWN_W-1:0] last_q;

	logic               valid_s1;
	logic               ovf_s1;
	logic               redraw_s1;
	logic [AVG_W-1:0]   x_s1;
	dot_t               dot_s1;

	logic               out_load;
	logic [DIGIT_W-1:0] hi;
	logic [6:0]         q10;
	logic [DIGIT_W-1:0] mid;
	logic [DIGIT_W-1:0] low;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic [OUT_USER_W-1:0] out_user_q;

	// average and distance from what is shown
	assign avg  = AVG_W'(status.sum / WINDOW_DEPTH);
	assign big  = avg >= BIG_LIMIT;
	assign diff = SHOWN_W'(avg) - last_q;
	assign mag  = diff[SHOWN_W-1] ? (~diff + SHOWN_W'(1)) : diff;
	assign thr  = big ? (THR_W'(hysteresis_step) << 3) + (THR_W'(hysteresis_step) << 1)
	                  : THR_W'(hysteresis_step);
	assign draw = !status.over_flag && (mag >= SHOWN_W'(thr));

	// value to split: averages of 1000..1023 drop to 100..102
	always_comb begin
		x_show = avg;
		if (big) begin
			if (avg >= AVG_W'(1020)) begin
				x_show = AVG_W'(102);
			end else if (avg >= AVG_W'(1010)) begin
				x_show = AVG_W'(101);
			end else begin
				x_show = AVG_W'(100);
			end
		end
	end

	// dot position per format
	always_comb begin
		if (format_mode == MODE_VOLTS) begin
			dot = big ? DOT_AFTER_MID : DOT_AFTER_HIGH;
		end else begin
			dot = big ? DOT_AFTER_HIGH : DOT_NONE;
		end
	end

	// pipeline flow
	assign out_load   = valid_s1 && (!out_valid_q || out_ready);
	assign take_ready = !valid_s1 || out_load;

	// stage 1 control and last shown value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_q   <= SHOWN_RST;
		end else begin
			if (disp_take) begin
				valid_s1 <= 1'b1;
			end else if (out_load) begin
				valid_s1 <= 1'b0;
			end
			if (disp_take && draw) begin
				last_q <= SHOWN_W'(avg);
			end
		end
	end

	// stage 1 payload, cleared fields when nothing new is drawn
	always_ff @(posedge clk) begin
		if (disp_take) begin
			ovf_s1    <= status.over_flag;
			redraw_s1 <= status.over_flag || draw;
			x_s1      <= draw ? x_show : '0;
			dot_s1    <= draw ? dot : DOT_NONE;
		end
	end

	// digit split
	assign hi  = div100(x_s1);
	assign q10 = div10(x_s1);
	assign mid = DIGIT_W'(q10 - 7'(hi) * 7'd10);
	assign low = DIGIT_W'(x_s1 - AVG_W'(q10) * AVG_W'(10));

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {2'b00, dot_s1, low, mid, hi};
			out_user_q <= {redraw_s1, ovf_s1};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign out_user  = out_user_q;

endmodule

// ===== rtl/core/meter_average_hysteresis_display.sv =====
// ----------------------------------------------------------------------------
// meter_average_hysteresis_display
// Meter channel: 32-reading moving average with hysteresis-gated display.
// ----------------------------------------------------------------------------
//  channel   dir  width                fields (low bit first)
//  s_axis    in   tdata 16, tuser 1    tdata: sample[9:0]; tuser: kind
//  m_axis    out  tdata 16, tuser 2    tdata: digit_high, digit_mid, digit_low,
//                                      dot_place; tuser: overflow, redraw
//  apb       in   paddr 4, pwdata 32   0x0 overflow_limit, 0x4 hysteresis_step,
//                                      0x8 format_mode
//
//  One word accepted per cycle while s_axis_tready is high; a sample
//  updates the running sum when it is accepted, the window cells shifting
//  together. A display word passes the decision stage, then the digit
//  split into the output register, before its result appears.
//  Reset clears the cells, sum and flags at once; no clearing pass.
//  s_axis_tready drops only while both pipeline stages hold words and the
//  output is stalled; samples produce no result.
// ----------------------------------------------------------------------------
module meter_average_hysteresis_display
	import mahd_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// sample / display request stream
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // [9:0] sample, rest zero
	input  logic                  s_axis_tuser,  // [0] kind
	// display result stream
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [OUT_DATA_W-1:0] m_axis_tdata,  // [3:0] digit_high, [7:4] digit_mid,
	                                             // [11:8] digit_low, [13:12] dot_place
	output logic [OUT_USER_W-1:0] m_axis_tuser,  // [0] overflow, [1] redraw
	// configuration
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	logic [LIMIT_W-1:0] limit_q;
	logic [STEP_W-1:0]  step_q;
	logic               mode_q;
	logic               cfg_wr;
	reg_idx_t           reg_idx;
	logic               in_take;
	logic               sample_take;
	logic               disp_take;
	win_status_t        status;

	// register file
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RST;
			step_q  <= STEP_RST;
			mode_q  <= MODE_VOLTS;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LIMIT: limit_q <= pwdata[LIMIT_W-1:0];
				REG_STEP:  step_q  <= pwdata[STEP_W-1:0];
				REG_MODE:  mode_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		unique case (reg_idx)
			REG_LIMIT: prdata = APB_DATA_W'(limit_q);
			REG_STEP:  prdata = APB_DATA_W'(step_q);
			REG_MODE:  prdata = APB_DATA_W'(mode_q);
			default:   prdata = '0;
		endcase
	end

	// input word split by kind
	assign in_take     = s_axis_tvalid && s_axis_tready;
	assign sample_take = in_take && (s_axis_tuser == KIND_SAMPLE);
	assign disp_take   = in_take && (s_axis_tuser == KIND_DISPLAY);

	mahd_window u_window (
		.clk            (clk),
		.arst_n         (arst_n),
		.sample_take    (sample_take),
		.sample         (s_axis_tdata[SAMPLE_W-1:0]),
		.overflow_limit (limit_q),
		.status         (status)
	);

	mahd_display u_display (
		.clk             (clk),
		.arst_n          (arst_n),
		.disp_take       (disp_take),
		.take_ready      (s_axis_tready),
		.status          (status),
		.hysteresis_step (step_q),
		.format_mode     (mode_q),
		.out_valid       (m_axis_tvalid),
		.out_ready       (m_axis_tready),
		.out_data        (m_axis_tdata),
		.out_user        (m_axis_tuser)
	);

endmodule

// ===== rtl/core/mahd_checker.sv =====
// ----------------------------------------------------------------------------
// mahd_checker
// Port-level checks on the display result stream.
// ----------------------------------------------------------------------------
`include "meter_average_hysteresis_display_macros.svh"

module mahd_checker
	import mahd_pkg::*;
(
	input logic                  clk,
	input logic                  arst_n,
	input logic                  m_axis_tvalid,
	input logic                  m_axis_tready,
	input logic [OUT_DATA_W-1:0] m_axis_tdata,
	input logic [OUT_USER_W-1:0] m_axis_tuser
);

	// stalled result word holds
	`MAHD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

	// every digit decimal, dot code defined
	`MAHD_ASSERT_IMPL(a_digits, m_axis_tvalid, (m_axis_tdata[3:0] <= 4'd9) && (m_axis_tdata[7:4] <= 4'd9) && (m_axis_tdata[11:8] <= 4'd9) && (m_axis_tdata[13:12] != 2'd3), "bad digit or dot code")

	// overload is always a redraw with blank digits
	`MAHD_ASSERT_IMPL(a_overload, m_axis_tvalid && m_axis_tuser[0], m_axis_tuser[1] && (m_axis_tdata == '0), "overload word malformed")

	// kept display carries no digits
	`MAHD_ASSERT_IMPL(a_keep, m_axis_tvalid && !m_axis_tuser[1], m_axis_tdata == '0, "kept display word not blank")

endmodule

bind meter_average_hysteresis_display mahd_checker u_mahd_checker (.*);
